// File: src/iedc_pkg.sv
`default_nettype none
package iedc_pkg;

  // sizing of the block
  localparam int MAX_DIVISORS = 4;
  localparam int VALUE_WIDTH  = 32;
  localparam int COUNT_WIDTH  = 3;
  localparam int TOTAL_WIDTH  = VALUE_WIDTH + 2;
  localparam int MASK_WIDTH   = MAX_DIVISORS;
  localparam int NUM_WIDTH    = $clog2(MAX_DIVISORS + 1);
  localparam int SEL_WIDTH    = (MAX_DIVISORS > 1) ? $clog2(MAX_DIVISORS) : 1;
  localparam int CFG_IDX_WIDTH = $clog2(MAX_DIVISORS + 1);
  localparam int STEP_WIDTH   = $clog2(VALUE_WIDTH);

  // register map
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_COUNT        = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DIVISOR_BASE = CFG_IDX_WIDTH'(1);

  // reset values of the registers
  localparam logic [COUNT_WIDTH-1:0] RESET_COUNT = COUNT_WIDTH'(3);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MCHK,
    ST_DSTART,
    ST_DWAIT,
    ST_ACCUM,
    ST_FINISH
  } state_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // reset value of divisor register i
  function automatic logic [VALUE_WIDTH-1:0] reset_divisor(input int i);
    logic [VALUE_WIDTH-1:0] v;
    v = VALUE_WIDTH'(1);
    case (i)
      0: v = VALUE_WIDTH'(2);
      1: v = VALUE_WIDTH'(3);
      2: v = VALUE_WIDTH'(5);
      3: v = VALUE_WIDTH'(7);
      default: v = VALUE_WIDTH'(1);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: src/iedc_mul.sv
`default_nettype none
module iedc_mul
  import iedc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic [VALUE_WIDTH-1:0]   a,
  input  wire logic [VALUE_WIDTH-1:0]   b,
  output logic      [2*VALUE_WIDTH-1:0] product
);

  // full-width product, registered
  always_ff @(posedge clk) begin
    product <= (2*VALUE_WIDTH)'(a) * (2*VALUE_WIDTH)'(b);
  end

endmodule
`default_nettype wire

// File: src/iedc_div.sv
`default_nettype none
module iedc_div
  import iedc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output logic      [VALUE_WIDTH-1:0] quotient,
  output div_status_t                 status
);

  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic [STEP_WIDTH-1:0]  step;
  logic                   running;
  logic                   done;
  logic [VALUE_WIDTH:0]   trial;

  // trial subtraction of the shifted partial remainder
  assign trial = {rem, quo[VALUE_WIDTH-1]} - {1'b0, divisor};

  // control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_WIDTH'(1);
        if (step == STEP_WIDTH'(VALUE_WIDTH - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // restoring datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (running) begin
      if (!trial[VALUE_WIDTH]) begin
        rem <= trial[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem <= {rem[VALUE_WIDTH-2:0], quo[VALUE_WIDTH-1]};
        quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = running;
  assign status.done = done;

endmodule
`default_nettype wire

// File: src/inclusion_exclusion_divisible_count.sv
`default_nettype none
// per subset: each nonempty subset of the divisors in use is handled by a scan
// over every divisor in use, a product check per divisor in the subset, the end
// of the scan, the divider start, a wait for its done and the accumulate (an
// overshooting product skips the divider); busy stays high from start until
// done, start is taken only while idle, so no new item before done; the receiver
// cannot stall. synchronous reset restores divisors 2, 3, 5, 7, count three, idle.
module inclusion_exclusion_divisible_count
  import iedc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [VALUE_WIDTH-1:0]   limit,
  output logic                          done,
  output logic      [VALUE_WIDTH-1:0]   divisible_count,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [VALUE_WIDTH-1:0]   cfg_wdata
);

  state_t state, state_next;

  logic [COUNT_WIDTH-1:0] divisor_count;
  logic [VALUE_WIDTH-1:0] divisors [MAX_DIVISORS];

  logic [VALUE_WIDTH-1:0] limit_r;
  logic [MASK_WIDTH-1:0]  subset_mask;
  logic [NUM_WIDTH-1:0]   bit_idx;
  logic [VALUE_WIDTH-1:0] subset_product;
  logic                   sat;
  logic [TOTAL_WIDTH-1:0] running_total;

  logic [NUM_WIDTH-1:0]     active_n;
  logic [MASK_WIDTH:0]      last_wide;
  logic [MASK_WIDTH-1:0]    last_mask;
  logic [SEL_WIDTH-1:0]     sel;
  logic [VALUE_WIDTH-1:0]   div_raw;
  logic [VALUE_WIDTH-1:0]   div_eff;
  logic                     scan_end;
  logic                     bit_set;
  logic                     odd_subset;
  logic [VALUE_WIDTH-1:0]   add_val;
  logic [2*VALUE_WIDTH-1:0] mul_product;
  logic [VALUE_WIDTH-1:0]   div_quotient;
  div_status_t              div_status;
  logic                     div_start;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_count <= RESET_COUNT;
      for (int i = 0; i < MAX_DIVISORS; i++) begin
        divisors[i] <= reset_divisor(i);
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_COUNT) begin
        divisor_count <= cfg_wdata[COUNT_WIDTH-1:0];
      end
      for (int i = 0; i < MAX_DIVISORS; i++) begin
        if (cfg_index == CFG_DIVISOR_BASE + CFG_IDX_WIDTH'(i)) begin
          divisors[i] <= cfg_wdata;
        end
      end
    end
  end

  // divisors in use, saturated, and the last subset mask
  always_comb begin
    if (32'(divisor_count) > 32'(MAX_DIVISORS)) begin
      active_n = NUM_WIDTH'(MAX_DIVISORS);
    end else begin
      active_n = NUM_WIDTH'(divisor_count);
    end
    last_wide = ((MASK_WIDTH+1)'(1) << active_n) - (MASK_WIDTH+1)'(1);
    last_mask = last_wide[MASK_WIDTH-1:0];
  end

  // current divisor under the scan pointer, zero read as one
  assign sel      = bit_idx[SEL_WIDTH-1:0];
  assign scan_end = (bit_idx == active_n);
  assign bit_set  = !scan_end && subset_mask[sel];
  assign div_raw  = divisors[sel];
  assign div_eff  = (div_raw == '0) ? VALUE_WIDTH'(1) : div_raw;

  // sign of the subset term and its magnitude
  assign odd_subset = $countones(subset_mask) % 2 == 1;
  assign add_val    = sat ? '0 : div_quotient;

  iedc_mul u_mul (
    .clk     (clk),
    .a       (subset_product),
    .b       (div_eff),
    .product (mul_product)
  );

  iedc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (limit_r),
    .divisor  (subset_product),
    .quotient (div_quotient),
    .status   (div_status)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (active_n == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = sat ? ST_ACCUM : ST_DSTART;
        end else if (bit_set && !sat) begin
          state_next = ST_MCHK;
        end
      end
      ST_MCHK:   state_next = ST_SCAN;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT: begin
        if (div_status.done) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_next = (subset_mask == last_mask) ? ST_FINISH : ST_SCAN;
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_IDLE:   busy      = 1'b0;
      ST_DSTART: div_start = 1'b1;
      ST_FINISH: done      = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // subset walk datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      subset_mask    <= '0;
      running_total  <= '0;
      subset_product <= VALUE_WIDTH'(1);
      sat            <= 1'b0;
      bit_idx        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            limit_r        <= limit;
            running_total  <= '0;
            subset_mask    <= MASK_WIDTH'(1);
            subset_product <= VALUE_WIDTH'(1);
            sat            <= 1'b0;
            bit_idx        <= '0;
          end
        end
        ST_SCAN: begin
          if (!scan_end && !(bit_set && !sat)) begin
            bit_idx <= bit_idx + NUM_WIDTH'(1);
          end
        end
        ST_MCHK: begin
          if (mul_product > (2*VALUE_WIDTH)'(limit_r)) begin
            sat <= 1'b1;
          end else begin
            subset_product <= mul_product[VALUE_WIDTH-1:0];
          end
          bit_idx <= bit_idx + NUM_WIDTH'(1);
        end
        ST_ACCUM: begin
          if (odd_subset) begin
            running_total <= running_total + TOTAL_WIDTH'(add_val);
          end else begin
            running_total <= running_total - TOTAL_WIDTH'(add_val);
          end
          if (subset_mask != last_mask) begin
            subset_mask    <= subset_mask + MASK_WIDTH'(1);
            subset_product <= VALUE_WIDTH'(1);
            sat            <= 1'b0;
            bit_idx        <= '0;
          end
        end
        default: begin
          sat <= sat;
        end
      endcase
    end
  end

  // result beat
  assign divisible_count = running_total[VALUE_WIDTH-1:0];

endmodule
`default_nettype wire
